/* sv/calib_sentence_parser_defines.svh */
// Assertion macros shared by the calibration sentence parser.
`ifndef CALIB_SENTENCE_PARSER_DEFINES_SVH
`define CALIB_SENTENCE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CSPAR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CSPAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cspar_pkg.sv */
// Types, constants and helpers for the calibration sentence parser.
`default_nettype none
package cspar_pkg;

  localparam int MAX_FRACTION_DIGITS = 5;
  localparam int FRAC_W = 3;
  localparam int HDR_W = 3;
  localparam int VAL_W = 32;

  localparam logic [HDR_W-1:0] HDR_LEN = 3'd6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  localparam logic [1:0] FIELD_NONE  = 2'd0;
  localparam logic [1:0] FIELD_BUCK  = 2'd1;
  localparam logic [1:0] FIELD_BOOST = 2'd2;
  localparam logic [1:0] FIELD_REST  = 2'd3;

  typedef struct packed {
    logic              neg;
    logic              point;
    logic              illegal;
    logic              any_digit;
    logic [FRAC_W-1:0] frac;
    logic [VAL_W-1:0]  acc;
  } field_t;

  localparam field_t FIELD_CLEAR = '{neg: 1'b0, point: 1'b0, illegal: 1'b0,
                                     any_digit: 1'b0, frac: '0, acc: '0};

  typedef struct packed {
    logic [HDR_W-1:0] progress_next;
    logic             done;
  } hdr_status_t;

  function automatic logic [7:0] hdr_char(input logic [HDR_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = CH_DOLLAR;
      3'd1:    ch = CH_C;
      3'd2:    ch = CH_A;
      3'd3:    ch = CH_L;
      3'd4:    ch = CH_I;
      3'd5:    ch = CH_B;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

/* sv/cspar_in_if.sv */
// Text byte channel: valid/ready handshake with one character payload.
`default_nettype none
interface cspar_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

/* sv/cspar_out_if.sv */
// Result channel: valid/ready handshake with both offsets and update flags.
`default_nettype none
interface cspar_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] buck_offset;
  logic signed [31:0] boost_offset;
  logic               buck_updated;
  logic               boost_updated;

  modport source (output valid, output buck_offset, output boost_offset,
                  output buck_updated, output boost_updated, input ready);
  modport sink (input valid, input buck_offset, input boost_offset,
                input buck_updated, input boost_updated, output ready);
endinterface
`default_nettype wire

/* sv/cspar_hdr_match.sv */
// Header matcher: advances the $CALIB match count by one character.
`default_nettype none
module cspar_hdr_match (
  input  wire logic [cspar_pkg::HDR_W-1:0] progress,
  input  wire logic [7:0]                  text_byte,
  output cspar_pkg::hdr_status_t           status
);

  logic match;

  always_comb begin
    match = (progress < cspar_pkg::HDR_LEN) &&
            (text_byte == cspar_pkg::hdr_char(progress));
    if (match) begin
      status.progress_next = progress + 3'd1;
    end else if (text_byte == cspar_pkg::CH_DOLLAR) begin
      // restart on '$' as the first header character
      status.progress_next = 3'd1;
    end else begin
      status.progress_next = 3'd0;
    end
    status.done = (status.progress_next == cspar_pkg::HDR_LEN);
  end

endmodule
`default_nettype wire

/* sv/cspar_field_take.sv */
// Field digit parser: folds one character into the open field.
`default_nettype none
module cspar_field_take (
  input  wire logic [7:0]        text_byte,
  input  wire cspar_pkg::field_t fld,
  output cspar_pkg::field_t      fld_next
);

  logic                             is_digit;
  logic [cspar_pkg::VAL_W-1:0]      digit;
  logic [cspar_pkg::VAL_W-1:0]      mac;

  always_comb begin
    is_digit = (text_byte >= cspar_pkg::CH_ZERO) && (text_byte <= cspar_pkg::CH_NINE);
    digit    = {{(cspar_pkg::VAL_W-4){1'b0}}, text_byte[3:0]};
    // times ten as shift-add, wraps mod 2^32
    mac      = (fld.acc << 3) + (fld.acc << 1) + digit;
    fld_next = fld;
    if (!fld.illegal) begin
      if (is_digit) begin
        if (!fld.point) begin
          fld_next.acc = mac;
        end else if (fld.frac <
                     cspar_pkg::FRAC_W'(cspar_pkg::MAX_FRACTION_DIGITS)) begin
          fld_next.acc  = mac;
          fld_next.frac = fld.frac + 3'd1;
        end
        fld_next.any_digit = 1'b1;
      end else if (text_byte == cspar_pkg::CH_POINT) begin
        if (fld.point) begin
          fld_next.illegal = 1'b1;
        end else begin
          fld_next.point     = 1'b1;
          fld_next.any_digit = 1'b1;
        end
      end else if (text_byte == cspar_pkg::CH_MINUS) begin
        // minus only in leading position
        if (!fld.neg && !fld.any_digit) begin
          fld_next.neg = 1'b1;
        end else begin
          fld_next.illegal = 1'b1;
        end
      end else begin
        fld_next.illegal = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/calib_sentence_parser.sv */
// A terminating byte is held in the input register (s1), and its sentence result is then
// written into the output register, from which it is offered.
// Throughput: one byte per cycle; the input register stalls only while a
// finished result waits in the output register and the next byte ends a sentence.
// Reset (rst, synchronous): header hunt restarts, both stored offsets clear to zero.
`default_nettype none
`include "calib_sentence_parser_defines.svh"
module calib_sentence_parser (
  input  wire logic    clk,
  input  wire logic    rst,
  cspar_in_if.sink     text,
  cspar_out_if.source  result
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // parser state
  logic [cspar_pkg::HDR_W-1:0] hdr_progress, hdr_progress_next;
  logic                        in_body, in_body_next;
  logic [1:0]                  field_num, field_num_next;
  cspar_pkg::field_t           fld, fld_next, fld_take;
  logic [cspar_pkg::VAL_W-1:0] buck_store, buck_store_next;
  logic [cspar_pkg::VAL_W-1:0] boost_store, boost_store_next;

  // output register
  logic                        out_valid;
  logic [cspar_pkg::VAL_W-1:0] out_buck, out_boost;
  logic                        out_buck_upd, out_boost_upd;

  cspar_pkg::hdr_status_t      hdr_stat;
  logic                        is_term, in_field, term_illegal, emit, s1_go;
  logic [cspar_pkg::VAL_W-1:0] close_val;

  cspar_hdr_match u_hdr (
    .progress  (hdr_progress),
    .text_byte (s1_byte),
    .status    (hdr_stat)
  );

  cspar_field_take u_take (
    .text_byte (s1_byte),
    .fld       (fld),
    .fld_next  (fld_take)
  );

  always_comb begin
    is_term = (s1_byte == cspar_pkg::CH_STAR) || (s1_byte < cspar_pkg::CH_SPACE) ||
              (s1_byte > cspar_pkg::CH_LOW_Z);
    in_field = (field_num == cspar_pkg::FIELD_BUCK) ||
               (field_num == cspar_pkg::FIELD_BOOST);
    // control byte or byte above 'z' spoils an open field
    term_illegal = is_term && (s1_byte != cspar_pkg::CH_STAR) && in_field;
    if (fld.illegal || term_illegal) begin
      close_val = '0;
    end else if (fld.neg) begin
      close_val = '0 - fld.acc;
    end else begin
      close_val = fld.acc;
    end
    emit = in_body && is_term;
    s1_go = s1_valid && (!emit || !out_valid || result.ready);
  end

  always_comb begin
    hdr_progress_next = hdr_progress;
    in_body_next      = in_body;
    field_num_next    = field_num;
    fld_next          = fld;
    buck_store_next   = buck_store;
    boost_store_next  = boost_store;
    if (!in_body) begin
      hdr_progress_next = hdr_stat.progress_next;
      if (hdr_stat.done) begin
        hdr_progress_next = '0;
        in_body_next      = 1'b1;
        field_num_next    = cspar_pkg::FIELD_NONE;
        fld_next          = cspar_pkg::FIELD_CLEAR;
      end
    end else if (is_term) begin
      if (field_num == cspar_pkg::FIELD_BUCK) begin
        buck_store_next = close_val;
      end else if (field_num == cspar_pkg::FIELD_BOOST) begin
        boost_store_next = close_val;
      end
      fld_next          = cspar_pkg::FIELD_CLEAR;
      in_body_next      = 1'b0;
      hdr_progress_next = '0;
      field_num_next    = cspar_pkg::FIELD_NONE;
    end else if (s1_byte == cspar_pkg::CH_COMMA) begin
      // after the third comma, drop everything to the end
      if (field_num != cspar_pkg::FIELD_REST) begin
        if (field_num == cspar_pkg::FIELD_BUCK) begin
          buck_store_next = close_val;
        end else if (field_num == cspar_pkg::FIELD_BOOST) begin
          boost_store_next = close_val;
        end
        fld_next       = cspar_pkg::FIELD_CLEAR;
        field_num_next = field_num + 2'd1;
      end
    end else if (in_field) begin
      fld_next = fld_take;
    end
  end

  assign text.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (text.valid && text.ready) begin
      s1_byte <= text.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_progress <= '0;
      in_body      <= 1'b0;
      field_num    <= cspar_pkg::FIELD_NONE;
      fld          <= cspar_pkg::FIELD_CLEAR;
      buck_store   <= '0;
      boost_store  <= '0;
    end else if (s1_go) begin
      hdr_progress <= hdr_progress_next;
      in_body      <= in_body_next;
      field_num    <= field_num_next;
      fld          <= fld_next;
      buck_store   <= buck_store_next;
      boost_store  <= boost_store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && emit) begin
      out_buck      <= buck_store_next;
      out_boost     <= boost_store_next;
      out_buck_upd  <= (field_num != cspar_pkg::FIELD_NONE);
      out_boost_upd <= field_num[1];
    end
  end

  assign result.valid         = out_valid;
  assign result.buck_offset   = $signed(out_buck);
  assign result.boost_offset  = $signed(out_boost);
  assign result.buck_updated  = out_buck_upd;
  assign result.boost_updated = out_boost_upd;

  `CSPAR_ASSERT_NOW(a_ready_when_out_free, !out_valid, text.ready, "input stalled with free output")
  `CSPAR_ASSERT_NOW(a_flags_ordered, out_valid && out_boost_upd, out_buck_upd, "second field without first")
  `CSPAR_ASSERT_NOW(a_hdr_idle_in_body, in_body, hdr_progress == '0, "header count live in body")
  `CSPAR_ASSERT_NEXT(a_emit_leaves_body, s1_go && emit, !in_body && out_valid, "sentence end not taken")

endmodule
`default_nettype wire

/* test/calib_sentence_parser_tb.sv */
// Self-checking testbench for calib_sentence_parser: directed and random sentence streams.
`default_nettype none
module calib_sentence_parser_tb;

  // Tracks parser state byte by byte and queues the sentence results it expects.
  class calib_scoreboard;
    typedef struct {
      logic signed [31:0] buck;
      logic signed [31:0] boost;
      logic               buck_upd;
      logic               boost_upd;
    } offsets_t;

    offsets_t          pending[$];
    int                errors;
    int                results_checked;
    int                buck_updates;
    int                boost_updates;

    logic [7:0]        hdr_text [6];
    logic [cspar_pkg::HDR_W-1:0] hdr_pos;
    logic              in_body;
    logic [1:0]        field_no;
    logic              neg;
    logic              point;
    logic              illegal;
    logic              any_digit;
    int                frac;
    logic [31:0]       acc;
    logic signed [31:0] buck;
    logic signed [31:0] boost;

    function new();
      hdr_text = '{cspar_pkg::CH_DOLLAR, cspar_pkg::CH_C, cspar_pkg::CH_A,
                   cspar_pkg::CH_L, cspar_pkg::CH_I, cspar_pkg::CH_B};
      hdr_pos = '0;
      in_body = 1'b0;
      field_no = cspar_pkg::FIELD_NONE;
      buck = '0;
      boost = '0;
      clear_field();
    endfunction

    function void clear_field();
      neg = 1'b0;
      point = 1'b0;
      illegal = 1'b0;
      any_digit = 1'b0;
      frac = 0;
      acc = '0;
    endfunction

    function void close_field();
      logic [31:0] val;
      val = illegal ? 32'd0 : (neg ? 32'(32'd0 - acc) : acc);
      if (field_no == cspar_pkg::FIELD_BUCK) buck = val;
      else if (field_no == cspar_pkg::FIELD_BOOST) boost = val;
      clear_field();
    endfunction

    function void note_byte(logic [7:0] c);
      offsets_t res;
      if (!in_body) begin
        if (hdr_pos < cspar_pkg::HDR_LEN && c == hdr_text[hdr_pos]) hdr_pos = hdr_pos + 1'b1;
        else hdr_pos = (c == cspar_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
        if (hdr_pos == cspar_pkg::HDR_LEN) begin
          hdr_pos = '0;
          in_body = 1'b1;
          field_no = cspar_pkg::FIELD_NONE;
          clear_field();
        end
      end else if (c == cspar_pkg::CH_STAR || c < cspar_pkg::CH_SPACE ||
                   c > cspar_pkg::CH_LOW_Z) begin
        // a control or high byte spoils an open offset field
        if (c != cspar_pkg::CH_STAR &&
            (field_no == cspar_pkg::FIELD_BUCK || field_no == cspar_pkg::FIELD_BOOST))
          illegal = 1'b1;
        close_field();
        res.buck = buck;
        res.boost = boost;
        res.buck_upd = (field_no >= cspar_pkg::FIELD_BUCK);
        res.boost_upd = (field_no >= cspar_pkg::FIELD_BOOST);
        pending.push_back(res);
        in_body = 1'b0;
        hdr_pos = '0;
        field_no = cspar_pkg::FIELD_NONE;
      end else if (c == cspar_pkg::CH_COMMA) begin
        if (field_no != cspar_pkg::FIELD_REST) begin
          close_field();
          field_no = field_no + 1'b1;
        end
      end else if ((field_no == cspar_pkg::FIELD_BUCK || field_no == cspar_pkg::FIELD_BOOST) &&
                   !illegal) begin
        if (c >= cspar_pkg::CH_ZERO && c <= cspar_pkg::CH_NINE) begin
          // drop fraction digits past the kept count
          if (!point || frac < cspar_pkg::MAX_FRACTION_DIGITS) begin
            acc = acc * 32'd10 + 32'(c - cspar_pkg::CH_ZERO);
            if (point) frac++;
          end
          any_digit = 1'b1;
        end else if (c == cspar_pkg::CH_POINT) begin
          if (point) illegal = 1'b1;
          else begin
            point = 1'b1;
            any_digit = 1'b1;
          end
        end else if (c == cspar_pkg::CH_MINUS) begin
          if (!neg && !any_digit) neg = 1'b1;
          else illegal = 1'b1;
        end else begin
          illegal = 1'b1;
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d (0x%08h) actual %0d (0x%08h)", $time, name,
                 $signed(exp_val), exp_val, $signed(act_val), act_val);
      end
    endfunction

    function void check_result(logic signed [31:0] buck_act, logic signed [31:0] boost_act,
                               logic buck_upd_act, logic boost_upd_act);
      offsets_t exp_res;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual buck %0d boost %0d flags %b%b",
                 $time, buck_act, boost_act, buck_upd_act, boost_upd_act);
        return;
      end
      exp_res = pending.pop_front();
      results_checked++;
      if (exp_res.buck_upd) buck_updates++;
      if (exp_res.boost_upd) boost_updates++;
      compare_field("buck_offset", exp_res.buck, buck_act);
      compare_field("boost_offset", exp_res.boost, boost_act);
      compare_field("buck_updated", 32'(exp_res.buck_upd), 32'(buck_upd_act));
      compare_field("boost_updated", 32'(exp_res.boost_upd), 32'(boost_upd_act));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_left;
  int   bytes_sent;

  calib_scoreboard sb;

  cspar_in_if  text_chan ();
  cspar_out_if result_chan ();

  calib_sentence_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_chan),
    .result (result_chan)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: random stalls, or a long hold-off while hold_left counts down.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      result_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      result_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_chan.valid && result_chan.ready)
      sb.check_result(result_chan.buck_offset, result_chan.boost_offset,
                      result_chan.buck_updated, result_chan.boost_updated);
  end

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      text_chan.valid <= 1'b0;
      @(negedge clk);
    end
    text_chan.valid <= 1'b1;
    text_chan.text_byte <= b;
    do @(posedge clk); while (!text_chan.ready);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] junk_char();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'h7A));
    while (b == cspar_pkg::CH_COMMA || b == cspar_pkg::CH_STAR);
    return b;
  endfunction

  task automatic send_random_field();
    int kind;
    int n_int;
    kind = $urandom_range(99);
    if (kind < 5) return;
    if ($urandom_range(2) == 0) send_byte(cspar_pkg::CH_MINUS);
    n_int = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
    repeat (n_int) send_byte(cspar_pkg::CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(1) == 1) begin
      send_byte(cspar_pkg::CH_POINT);
      repeat ($urandom_range(0, 8)) send_byte(cspar_pkg::CH_ZERO + 8'($urandom_range(9)));
    end
    // follow some fields with a stray character, which may spoil them, and up to two more digits
    if (kind >= 86) begin
      send_byte(junk_char());
      repeat ($urandom_range(0, 2)) send_byte(cspar_pkg::CH_ZERO + 8'($urandom_range(9)));
    end
  endtask

  task automatic send_random_sentence();
    int         commas;
    int         pick;
    logic [7:0] term;
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
    if ($urandom_range(9) == 0) send_text("$CA");
    send_text("$CALIB");
    repeat ($urandom_range(0, 2)) send_byte(junk_char());
    pick = $urandom_range(99);
    commas = (pick < 5) ? 0 : (pick < 20) ? 1 : (pick < 80) ? 2 : $urandom_range(3, 4);
    for (int i = 0; i < commas; i++) begin
      send_byte(cspar_pkg::CH_COMMA);
      if (i < 2) send_random_field();
      else repeat ($urandom_range(0, 2)) send_byte(junk_char());
    end
    pick = $urandom_range(99);
    if (pick < 78) begin
      send_byte(cspar_pkg::CH_STAR);
      // checksum and line end, seen while hunting
      send_byte(cspar_pkg::CH_ZERO + 8'($urandom_range(9)));
      send_byte(cspar_pkg::CH_A + 8'($urandom_range(5)));
      send_byte(8'h0D);
      send_byte(8'h0A);
    end else begin
      term = (pick < 89) ? 8'($urandom_range(8'h00, 8'h1F)) : 8'($urandom_range(8'h7B, 8'hFF));
      send_byte(term);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    text_chan.valid = 1'b0;
    text_chan.text_byte = 8'h00;
    result_chan.ready = 1'b0;
    hold_left = 0;
    bytes_sent = 0;
    send_idle_pct = 11;
    recv_idle_pct = 68;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: no comma, empty fields, sign and point rules, truncation, overflow,
    // header restart, terminators inside and after fields
    send_text("$CALIB");
    send_byte(cspar_pkg::CH_STAR);
    send_text("$CALIB,,");
    send_byte(cspar_pkg::CH_STAR);
    send_text("$CALIB,-1.5,.00001999");
    send_byte(cspar_pkg::CH_STAR);
    send_text("$$CALIB,1-2,1..2,9");
    send_byte(8'h01);
    send_text("$CA$CALIB,99999999999,-42949.67296");
    send_byte(8'hFF);
    send_text("xCALIB$CALIB,--1,7");
    send_byte(8'h7B);
    send_text("$CALIB,2,3");
    send_byte(8'h00);

    repeat (13) send_random_sentence();
    wait_drained();

    send_idle_pct = 68;
    recv_idle_pct = 11;
    repeat (13) send_random_sentence();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long receiver hold-off while sentences keep coming, then pause until drained
    hold_left = 400;
    repeat (3) send_random_sentence();
    wait_drained();
    repeat (9) send_random_sentence();

    text_chan.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d text bytes transferred, %0d sentence results checked", bytes_sent,
             sb.results_checked);
    $display("buck field present in %0d results, boost field in %0d", sb.buck_updates,
             sb.boost_updates);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("calib_sentence_parser_tb OK");
    end else begin
      $display("calib_sentence_parser_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("calib_sentence_parser_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
